[src/a32x_pkg.sv]
package a32x_pkg;

   localparam int NumRegsDefault = 16;
   localparam int DataWidth      = 32;

   typedef enum logic [1:0] {
      STATUS_COND_FAIL   = 2'd0,
      STATUS_EXECUTED    = 2'd1,
      STATUS_UNDEFINED   = 2'd2,
      STATUS_UNSUPPORTED = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_AND = 4'h0, OP_EOR = 4'h1, OP_SUB = 4'h2, OP_RSB = 4'h3,
      OP_ADD = 4'h4, OP_ADC = 4'h5, OP_SBC = 4'h6, OP_RSC = 4'h7,
      OP_TST = 4'h8, OP_TEQ = 4'h9, OP_CMP = 4'hA, OP_CMN = 4'hB,
      OP_ORR = 4'hC, OP_MOV = 4'hD, OP_BIC = 4'hE, OP_MVN = 4'hF
   } dp_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } state_type;

   localparam logic [0:0] CSR_START_PC = 1'b0;
   localparam logic [0:0] CSR_LINK     = 1'b1;

   typedef struct packed {
      logic        start;
      logic        is_signed;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        dest_valid;
      logic [3:0]  dest_index;
      logic [31:0] dest_value;
      logic [31:0] next_pc;
      logic [3:0]  flags_out;
   } result_type;

   function automatic logic cond_pass(input logic [3:0] cond, input logic [3:0] f);
      logic n, z, c, v;
      n = f[3]; z = f[2]; c = f[1]; v = f[0];
      unique case (cond)
         4'h0: return z;
         4'h1: return !z;
         4'h2: return c;
         4'h3: return !c;
         4'h4: return n;
         4'h5: return !n;
         4'h6: return v;
         4'h7: return !v;
         4'h8: return c && !z;
         4'h9: return !c || z;
         4'hA: return n == v;
         4'hB: return n != v;
         4'hC: return !z && (n == v);
         4'hD: return z || (n != v);
         4'hE: return 1'b1;
         default: return 1'b0;
      endcase
   endfunction

endpackage

[src/a32x_stream_if.sv]
interface a32x_stream_if #(parameter int Width = 32);
   logic             valid;
   logic             ready;
   logic [Width-1:0] payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

[src/a32x_divider.sv]
module a32x_divider (
   input  logic               clock,
   input  logic               reset,
   input  a32x_pkg::div_req_type req,
   output a32x_pkg::div_rsp_type rsp
);
   import a32x_pkg::*;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] an, am;

   always_comb begin
      an = (req.is_signed && req.dividend[31]) ? 32'(-req.dividend) : req.dividend;
      am = (req.is_signed && req.divisor[31]) ? 32'(-req.divisor) : req.divisor;
      trial = {rem_ff, quo_ff[31]} - {1'b0, den_ff};
      rem_in = rem_ff; quo_in = quo_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; neg_in = neg_ff; done_in = 1'b0;
      if (req.start) begin
         rem_in = '0; quo_in = an; den_in = am; cnt_in = 6'd32; busy_in = 1'b1;
         neg_in = req.is_signed && (req.dividend[31] ^ req.divisor[31]);
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = {rem_ff[30:0], quo_ff[31]};
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; quo_ff <= quo_in; den_ff <= den_in; neg_ff <= neg_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quotient = (den_ff == '0) ? '0 : (neg_ff ? 32'(-quo_ff) : quo_ff);
endmodule

[src/a32x_alu.sv]
module a32x_alu (
   input  logic [31:0] ins,
   input  logic [31:0] pc,
   input  logic [31:0] op_n,
   input  logic [31:0] op_m,
   input  logic [31:0] op_s,
   input  logic [3:0]  flags,
   output logic        wr,
   output logic [3:0]  wr_idx,
   output logic [31:0] wr_val,
   output logic [3:0]  flags_new,
   output logic        is_bx,
   output logic        is_branch,
   output logic [31:0] br_target,
   output logic        is_div,
   output logic        div_signed,
   output logic [1:0]  status
);
   import a32x_pkg::*;

   logic [1:0]  kind;
   logic        cf, sc, c, v;
   logic [31:0] op2, r, a, b, off;
   logic [32:0] sum;
   logic        cin, arith;
   logic [4:0]  amt, rot;
   logic [63:0] rr;
   logic        write;
   logic [31:0] mulr;
   dp_op_type   opc;

   always_comb begin
      kind = ins[27:26];
      cf = flags[1];
      opc = dp_op_type'(ins[24:21]);
      amt = ins[11:7];
      rot = {ins[11:8], 1'b0};
      op2 = '0; sc = cf; r = '0; a = '0; b = '0; cin = 1'b0; arith = 1'b0;
      rr = '0; sum = '0; write = 1'b1; c = cf; v = flags[0];
      wr = 1'b0; wr_idx = ins[15:12]; wr_val = '0; flags_new = flags;
      is_bx = 1'b0; is_branch = 1'b0; br_target = '0; is_div = 1'b0;
      div_signed = (ins[22:20] == 3'd1); status = STATUS_EXECUTED;
      mulr = 32'(op_m * op_s);
      off = {{6{ins[23]}}, ins[23:0], 2'b00};
      if (!cond_pass(ins[31:28], flags)) begin
         status = STATUS_COND_FAIL;
      end else if (kind == 2'd0) begin
         if ((ins & 32'h0FC000F0) == 32'h00000090) begin
            r = mulr + (ins[21] ? op_n : 32'd0);
            wr = 1'b1; wr_idx = ins[19:16]; wr_val = r;
            if (ins[20]) flags_new = {r[31], r == 32'd0, flags[1:0]};
         end else if ((ins & 32'h0FFFFFF0) == 32'h012FFF10) begin
            is_bx = 1'b1; br_target = op_m & ~32'd3;
         end else begin
            if (ins[25]) begin
               if (rot == 5'd0) begin
                  op2 = {24'd0, ins[7:0]}; sc = cf;
               end else begin
                  rr = {32'd0, 24'd0, ins[7:0]} << (6'd32 - {1'b0, rot});
                  op2 = rr[63:32] | rr[31:0];
                  sc = op2[31];
               end
            end else begin
               case (ins[6:5])
                  2'd0: begin
                     if (amt == 5'd0) begin
                        op2 = op_m; sc = cf;
                     end else begin
                        rr = {32'd0, op_m} << amt;
                        op2 = rr[31:0]; sc = rr[32];
                     end
                  end
                  2'd1: begin
                     if (amt == 5'd0) begin
                        op2 = '0; sc = op_m[31];
                     end else begin
                        rr = {op_m, 32'd0} >> amt;
                        op2 = rr[63:32]; sc = rr[31];
                     end
                  end
                  2'd2: begin
                     if (amt == 5'd0) begin
                        op2 = {32{op_m[31]}}; sc = op_m[31];
                     end else begin
                        rr = 64'($signed({op_m, 32'd0}) >>> amt);
                        op2 = rr[63:32]; sc = rr[31];
                     end
                  end
                  default: begin
                     if (amt == 5'd0) begin
                        op2 = {cf, op_m[31:1]}; sc = op_m[0];
                     end else begin
                        rr = {op_m, op_m} >> amt;
                        op2 = rr[31:0]; sc = op2[31];
                     end
                  end
               endcase
            end
            c = sc;
            case (opc) inside
               OP_SUB, OP_CMP: begin arith = 1'b1; a = op_n; b = ~op2; cin = 1'b1; end
               OP_RSB:         begin arith = 1'b1; a = op2; b = ~op_n; cin = 1'b1; end
               OP_ADD, OP_CMN: begin arith = 1'b1; a = op_n; b = op2; cin = 1'b0; end
               OP_ADC:         begin arith = 1'b1; a = op_n; b = op2; cin = cf; end
               OP_SBC:         begin arith = 1'b1; a = op_n; b = ~op2; cin = cf; end
               OP_RSC:         begin arith = 1'b1; a = op2; b = ~op_n; cin = cf; end
               default:        arith = 1'b0;
            endcase
            sum = {1'b0, a} + {1'b0, b} + {32'd0, cin};
            case (opc) inside
               OP_AND, OP_TST: r = op_n & op2;
               OP_EOR, OP_TEQ: r = op_n ^ op2;
               OP_ORR:         r = op_n | op2;
               OP_MOV:         r = op2;
               OP_BIC:         r = op_n & ~op2;
               OP_MVN:         r = ~op2;
               default:        r = sum[31:0];
            endcase
            if (arith) begin
               c = sum[32];
               v = ~(a[31] ^ b[31]) & (a[31] ^ sum[31]);
            end
            write = !(opc inside {OP_TST, OP_TEQ, OP_CMP, OP_CMN});
            wr = write; wr_val = r;
            if (ins[20]) flags_new = {r[31], r == 32'd0, c, v};
         end
      end else if (kind == 2'd1) begin
         if ((ins & 32'h0F80F0F0) == 32'h0700F010) begin
            is_div = 1'b1; wr_idx = ins[19:16];
         end else begin
            status = STATUS_UNSUPPORTED;
         end
      end else if (kind == 2'd2) begin
         if (!ins[25]) begin
            status = STATUS_UNSUPPORTED;
         end else begin
            is_branch = 1'b1;
            br_target = pc + 32'd8 + off;
            if (ins[24]) begin
               wr = 1'b1; wr_idx = 4'd14; wr_val = pc + 32'd4;
            end
         end
      end else begin
         status = STATUS_UNDEFINED;
      end
   end
endmodule

[src/arm32_execute_unit.sv]
// Executes one A32 instruction per request against a 16-entry register file and
// the NZCV flags, and returns one result per request. The register file is a
// memory with one registered read port, so a request reads its three operands
// one after another in the READ state, is executed in EXEC and presents its
// result in DONE; the next request is taken once the block is back in IDLE. A
// signed or unsigned divide passes from EXEC through the DIV state, where it
// waits on the bit-serial divider, before DONE. The block takes no new request
// until the result of the previous one has been taken. Writing start_pc or
// link_reset_value also loads r15 or r14 at once.
module arm32_execute_unit #(
   parameter int RegCount = a32x_pkg::NumRegsDefault
) (
   input  logic        clock,
   input  logic        reset,
   a32x_stream_if.sink req_if,
   a32x_stream_if.source rsp_if,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:2]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import a32x_pkg::*;

   localparam int IdxW = $clog2(RegCount);

   state_type   state_ff, state_in;
   logic [31:0] regs [RegCount];
   logic [31:0] rd_data_ff;
   logic [IdxW-1:0] rd_addr;
   logic [IdxW-1:0] rd_addr_ff;
   logic [31:0] pc_ff, pc_in;
   logic [3:0]  flags_ff, flags_in;
   logic [31:0] start_pc_ff, link_ff;
   logic [31:0] ins_ff, ins_in;
   logic [31:0] op_n_ff, op_m_ff, op_s_ff;
   logic [1:0]  rcnt_ff, rcnt_in;
   result_type  res_ff, res_in;
   logic        we;
   logic [IdxW-1:0] waddr;
   logic [31:0] wdata;
   logic        csr_we;
   div_req_type dreq;
   div_rsp_type drsp;
   logic        wr, is_bx, is_branch, is_div, div_signed;
   logic [3:0]  wr_idx, flags_new;
   logic [31:0] wr_val, br_target;
   logic [1:0]  status;

   assign csr_pready = 1'b1;
   assign csr_we = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_LINK) ? link_ff : start_pc_ff;

   a32x_alu u_alu (
      .ins(ins_ff), .pc(pc_ff), .op_n(op_n_ff), .op_m(op_m_ff), .op_s(op_s_ff),
      .flags(flags_ff), .wr(wr), .wr_idx(wr_idx), .wr_val(wr_val),
      .flags_new(flags_new), .is_bx(is_bx), .is_branch(is_branch),
      .br_target(br_target), .is_div(is_div), .div_signed(div_signed),
      .status(status)
   );

   a32x_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   always_comb begin
      unique case (rcnt_ff)
         2'd0: rd_addr = IdxW'(ins_ff[3:0]);
         2'd1: rd_addr = IdxW'(ins_ff[11:8]);
         default: rd_addr = (ins_ff[27:26] == 2'd0 && ins_ff[7:4] == 4'h9
                             && ins_ff[25:22] == 4'd0)
                            ? IdxW'(ins_ff[15:12]) : IdxW'(ins_ff[19:16]);
      endcase
   end

   always_comb begin
      state_in = state_ff; ins_in = ins_ff; rcnt_in = rcnt_ff; res_in = res_ff;
      pc_in = pc_ff; flags_in = flags_ff; we = 1'b0; waddr = '0; wdata = '0;
      dreq.start = 1'b0; dreq.is_signed = div_signed;
      dreq.dividend = op_m_ff; dreq.divisor = op_s_ff;
      req_if.ready = (state_ff == ST_IDLE);
      rsp_if.valid = (state_ff == ST_DONE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               ins_in = req_if.payload; rcnt_in = 2'd0; state_in = ST_READ;
            end
         end
         ST_READ: begin
            rcnt_in = rcnt_ff + 2'd1;
            if (rcnt_ff == 2'd3) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            res_in.status = status; res_in.flags_out = flags_new;
            res_in.dest_valid = 1'b0; res_in.dest_index = '0; res_in.dest_value = '0;
            res_in.next_pc = pc_ff + 32'd4;
            flags_in = flags_new;
            if (is_div) begin
               dreq.start = 1'b1; state_in = ST_DIV;
            end else begin
               if (is_bx || is_branch) res_in.next_pc = br_target;
               if (wr) begin
                  if (wr_idx == 4'd15) begin
                     res_in.next_pc = wr_val & ~32'd3;
                  end else begin
                     we = 1'b1; waddr = IdxW'(wr_idx); wdata = wr_val;
                     res_in.dest_valid = 1'b1; res_in.dest_index = wr_idx;
                     res_in.dest_value = wr_val;
                  end
               end
               pc_in = res_in.next_pc; state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (drsp.done) begin
               if (ins_ff[19:16] == 4'd15) begin
                  res_in.next_pc = drsp.quotient & ~32'd3;
               end else begin
                  we = 1'b1; waddr = IdxW'(ins_ff[19:16]); wdata = drsp.quotient;
                  res_in.dest_valid = 1'b1; res_in.dest_index = ins_ff[19:16];
                  res_in.dest_value = drsp.quotient;
               end
               pc_in = res_in.next_pc; state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_if.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we && csr_paddr[2] == CSR_START_PC) pc_in = csr_pwdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; flags_ff <= '0; pc_ff <= '0;
         start_pc_ff <= '0; link_ff <= '0; rcnt_ff <= '0;
      end else begin
         state_ff <= state_in; flags_ff <= flags_in; pc_ff <= pc_in; rcnt_ff <= rcnt_in;
         if (csr_we && csr_paddr[2] == CSR_START_PC) start_pc_ff <= csr_pwdata;
         if (csr_we && csr_paddr[2] == CSR_LINK) link_ff <= csr_pwdata;
      end
      ins_ff <= ins_in; res_ff <= res_in;
   end

   // Register file: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < RegCount; i++) regs[i] <= '0;
      end else if (csr_we && csr_paddr[2] == CSR_LINK) begin
         regs[14] <= csr_pwdata;
      end else if (we) begin
         regs[waddr] <= wdata;
      end
      rd_data_ff <= regs[rd_addr];
   end

   // Operand capture: read data arrives in the cycle after its address, so the address is registered alongside it.
   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
      if (state_ff == ST_READ) begin
         unique case (rcnt_ff)
            2'd1: op_m_ff <= (rd_addr_ff == IdxW'(15)) ? pc_ff + 32'd8 : rd_data_ff;
            2'd2: op_s_ff <= (rd_addr_ff == IdxW'(15)) ? pc_ff + 32'd8 : rd_data_ff;
            2'd3: op_n_ff <= (rd_addr_ff == IdxW'(15)) ? pc_ff + 32'd8 : rd_data_ff;
            default: ;
         endcase
      end
   end

   assign rsp_if.payload = {res_ff.status, res_ff.dest_valid, res_ff.dest_index,
                            res_ff.dest_value, res_ff.next_pc, res_ff.flags_out};
endmodule

[src/a32x_checker.sv]
module a32x_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [74:0] rsp_payload
);
   a_no_ready_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !rsp_valid) else $error("result too early");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid && $stable(rsp_payload))
      else $error("result dropped");
   a_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload[74:73] != 2'd1) |-> !rsp_payload[72])
      else $error("write reported without execution");
endmodule

bind arm32_execute_unit a32x_checker u_checker (
   .clock(clock), .reset(reset),
   .req_valid(req_if.valid), .req_ready(req_if.ready),
   .rsp_valid(rsp_if.valid), .rsp_ready(rsp_if.ready),
   .rsp_payload(rsp_if.payload)
);
